>>> src/blsd_pkg.sv
// ----------------------------------------------------------------------------
// blsd_pkg
// Shared types and constants for the bounded list search/delete block.
// ----------------------------------------------------------------------------
package blsd_pkg;

  localparam int unsigned DefDepth = 256;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LengthW = 9;

  typedef enum logic [OpW-1:0] {
    OP_APPEND     = 2'd0,
    OP_FIND       = 2'd1,
    OP_REMOVE_VAL = 2'd2,
    OP_REMOVE_AT  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

endpackage

>>> src/blsd_req_if.sv
// ----------------------------------------------------------------------------
// blsd_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface blsd_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [blsd_pkg::OpW-1:0]             op;
  logic signed [blsd_pkg::ValueW-1:0]   value;
  logic [blsd_pkg::PosW-1:0]            position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

>>> src/blsd_rsp_if.sv
// ----------------------------------------------------------------------------
// blsd_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface blsd_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [blsd_pkg::StatusW-1:0]     status;
  logic [blsd_pkg::PosW-1:0]        found_position;
  logic [blsd_pkg::LengthW-1:0]     length;

  modport source (output valid, output status, output found_position, output length,
                  input ready);
  modport sink   (input valid, input status, input found_position, input length,
                  output ready);
endinterface

>>> src/bounded_list_search_delete_top.sv
// ----------------------------------------------------------------------------
// bounded_list_search_delete_top
// Search and shift-down walk the entry RAM one entry per cycle through its single
// read port (one write port). One request at a time; ready returns with the result
// word, so a new request is taken only once the previous result word is loaded.
// Reset clears count and control; entry RAM is not cleared.
// ----------------------------------------------------------------------------
module bounded_list_search_delete_top #(
  parameter int unsigned DEPTH = blsd_pkg::DefDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  blsd_req_if.sink      req_i,
  blsd_rsp_if.source    rsp_o
);

  // count must hold DEPTH itself; addresses cover DEPTH entries
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;

  // request held for the life of the operation
  blsd_pkg::op_e                         op_q, op_d;
  logic [blsd_pkg::ValueW-1:0]           value_q, value_d;

  // scan pipeline: read issue index, then one stage of registered RAM data
  logic [CW-1:0]                 rd_idx_q, rd_idx_d;
  logic                          pv_q, pv_d;       // rd_data_q holds a live entry
  logic [AW-1:0]                 pi_q, pi_d;       // position of rd_data_q
  logic [blsd_pkg::ValueW-1:0]   rd_data_q;

  // staged result
  blsd_pkg::status_e             res_status_q, res_status_d;
  logic [blsd_pkg::PosW-1:0]     res_fpos_q, res_fpos_d;

  // output register
  logic                          out_vld_q, out_vld_d;
  blsd_pkg::status_e             out_status_q, out_status_d;
  logic [blsd_pkg::PosW-1:0]     out_fpos_q, out_fpos_d;
  logic [blsd_pkg::LengthW-1:0]  out_len_q, out_len_d;

  // RAM write port
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [blsd_pkg::ValueW-1:0]   wr_data;

  logic [blsd_pkg::ValueW-1:0]   mem [DEPTH];

  logic req_fire, rsp_fire, scan_end, hit;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid & req_i.ready;
  assign rsp_fire    = out_vld_q & rsp_o.ready;

  // nothing in flight and no more entries to read
  assign scan_end = !pv_q && (rd_idx_q >= count_q);
  assign hit      = pv_q && (rd_data_q == value_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    op_d         = op_q;
    value_d      = value_q;
    rd_idx_d     = rd_idx_q;
    pv_d         = 1'b0;
    pi_d         = pi_q;
    res_status_d = res_status_q;
    res_fpos_d   = res_fpos_q;
    wr_en        = 1'b0;
    wr_addr      = rd_idx_q[AW-1:0];
    wr_data      = value_q;

    // shared scan step: issue one read a cycle while entries remain
    if ((state_q == S_SEARCH || state_q == S_SHIFT) && (rd_idx_q < count_q)) begin
      pv_d     = 1'b1;
      pi_d     = rd_idx_q[AW-1:0];
      rd_idx_d = rd_idx_q + 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          op_d         = blsd_pkg::op_e'(req_i.op);
          value_d      = req_i.value;
          res_status_d = blsd_pkg::ST_OK;
          res_fpos_d   = '0;
          rd_idx_d     = '0;
          unique case (blsd_pkg::op_e'(req_i.op))
            blsd_pkg::OP_APPEND: begin
              if (count_q == CW'(DEPTH)) begin
                res_status_d = blsd_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = count_q[AW-1:0];
                wr_data = req_i.value;
                count_d = count_q + 1'b1;
              end
              state_d = S_DONE;
            end
            blsd_pkg::OP_FIND, blsd_pkg::OP_REMOVE_VAL: begin
              state_d = S_SEARCH;
            end
            blsd_pkg::OP_REMOVE_AT: begin
              if (32'(req_i.position) < 32'(count_q)) begin
                // shift starts reading at the entry above the hole
                rd_idx_d = CW'(req_i.position) + 1'b1;
                state_d  = S_SHIFT;
              end else begin
                res_status_d = blsd_pkg::ST_RANGE;
                state_d      = S_DONE;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_SEARCH: begin
        if (hit) begin
          pv_d = 1'b0;
          if (op_q == blsd_pkg::OP_FIND) begin
            res_fpos_d = blsd_pkg::PosW'(pi_q);
            state_d    = S_DONE;
          end else begin
            rd_idx_d = CW'(pi_q) + 1'b1;
            state_d  = S_SHIFT;
          end
        end else if (scan_end) begin
          res_status_d = blsd_pkg::ST_NOT_FOUND;
          state_d      = S_DONE;
        end
      end

      S_SHIFT: begin
        // entry at pi moves down one place
        if (pv_q) begin
          wr_en   = 1'b1;
          wr_addr = pi_q - 1'b1;
          wr_data = rd_data_q;
        end else if (scan_end) begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // output register: loads from DONE once the previous word has left
  always_comb begin
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_fpos_d   = out_fpos_q;
    out_len_d    = out_len_q;
    if (rsp_fire) begin
      out_vld_d = 1'b0;
    end
    if (state_q == S_DONE && (!out_vld_q || rsp_o.ready)) begin
      out_vld_d    = 1'b1;
      out_status_d = res_status_q;
      out_fpos_d   = res_fpos_q;
      out_len_d    = blsd_pkg::LengthW'(count_q);
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.found_position = out_fpos_q;
  assign rsp_o.length         = out_len_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pv_q      <= pv_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    value_q      <= value_d;
    rd_idx_q     <= rd_idx_d;
    pi_q         <= pi_d;
    res_status_q <= res_status_d;
    res_fpos_q   <= res_fpos_d;
    out_status_q <= out_status_d;
    out_fpos_q   <= out_fpos_d;
    out_len_q    <= out_len_d;
  end

  // entry RAM: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_idx_q[AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("count exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != S_IDLE))
    else $error("sequencer idle right after accepting a request");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_DONE))
    else $error("result word raised outside DONE");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q == S_IDLE) || $past(state_q == S_SHIFT)))
    else $error("count changed outside append or shift end");

  a_shift_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && wr_en) |-> (pi_q != '0))
    else $error("shift write below position zero");

endmodule

>>> dv/blsd_list_checker.sv
// ----------------------------------------------------------------------------
// blsd_list_checker
// Watches the request and result channels and keeps its own copy of the
// list. Each accepted request word is applied to that copy, and the result it
// should give is queued. Each accepted result word is compared field by field
// with the oldest queued one. Mismatches go to fail_count_o.
// ----------------------------------------------------------------------------
module blsd_list_checker #(
  parameter int unsigned Depth = blsd_pkg::DefDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  blsd_req_if  req_i,
  blsd_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   list_len_o
);

  typedef struct packed {
    blsd_pkg::status_e                  status;
    logic [blsd_pkg::PosW-1:0]          fpos;
    logic [blsd_pkg::LengthW-1:0]       len;
  } list_rsp_t;

  logic signed [blsd_pkg::ValueW-1:0] list_q[$];
  list_rsp_t                          rsp_expect_q[$];

  // Applies one request to the shadow list and returns the result it gives.
  function automatic list_rsp_t apply_request(blsd_pkg::op_e op,
                                              logic signed [blsd_pkg::ValueW-1:0] v,
                                              logic [blsd_pkg::PosW-1:0] p);
    list_rsp_t r;
    int        hit;
    r.status = blsd_pkg::ST_OK;
    r.fpos   = '0;
    hit      = -1;
    case (op)
      blsd_pkg::OP_APPEND: begin
        if (list_q.size() >= Depth) r.status = blsd_pkg::ST_FULL;
        else list_q.push_back(v);
      end
      blsd_pkg::OP_FIND, blsd_pkg::OP_REMOVE_VAL: begin
        foreach (list_q[i]) if (hit < 0 && list_q[i] == v) hit = i;
        if (hit < 0) r.status = blsd_pkg::ST_NOT_FOUND;
        else if (op == blsd_pkg::OP_FIND) r.fpos = blsd_pkg::PosW'(hit);
        else list_q.delete(hit);
      end
      default: begin
        if (int'(p) < list_q.size()) list_q.delete(int'(p));
        else r.status = blsd_pkg::ST_RANGE;
      end
    endcase
    r.len = blsd_pkg::LengthW'(list_q.size());
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_rsp_t exp_rsp;
    if (!rst_ni) begin
      list_q.delete();
      rsp_expect_q.delete();
      fail_count_o = 0;
    end else begin
      // result side first: a word accepted on this edge belongs to an
      // earlier request, never to one accepted on the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (rsp_expect_q.size() == 0) begin
          $error("result word with no request outstanding");
          fail_count_o++;
        end else begin
          exp_rsp = rsp_expect_q.pop_front();
          if (rsp_i.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, rsp_i.status);
            fail_count_o++;
          end
          if (rsp_i.found_position !== exp_rsp.fpos) begin
            $error("found_position: expected %0d, got %0d", exp_rsp.fpos,
                   rsp_i.found_position);
            fail_count_o++;
          end
          if (rsp_i.length !== exp_rsp.len) begin
            $error("length: expected %0d, got %0d", exp_rsp.len, rsp_i.length);
            fail_count_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        rsp_expect_q.push_back(apply_request(blsd_pkg::op_e'(req_i.op), req_i.value,
                                             req_i.position));
      end
    end
    pending_o  = rsp_expect_q.size();
    list_len_o = list_q.size();
  end

endmodule

>>> dv/tb_bounded_list_search_delete_top.sv
// ----------------------------------------------------------------------------
// tb_bounded_list_search_delete_top
// Drives append/find/remove requests into the list block and lets the
// checker predict and compare every result word. A directed opening covers
// the empty list, extreme values, duplicates and out-of-range positions;
// random phases then grow the list to full, shrink it and mix all ops,
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_bounded_list_search_delete_top;

  localparam int unsigned ItemCount  = 850;  // random request words
  localparam int unsigned QuietItems = 80;   // tail with no stalls at all
  localparam int unsigned TailCycles = 300;  // > one full-list walk
  localparam longint      LimitTime  = 40_000_000;

  // stimulus phases: mixed ops, grow to full, shrink
  typedef enum logic [1:0] {
    PH_MIX,
    PH_GROW,
    PH_SHRINK
  } phase_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  blsd_req_if req_if ();
  blsd_rsp_if rsp_if ();

  int fail_cnt;
  int pending;
  int list_len;

  bit quiet;   // last part of the run: no stalls on either side
  bit gaps_en; // sender gaps on/off, flipped now and then

  // value pool: extremes and a few repeats so finds and removes hit, and
  // duplicates exercise the lowest-position rule
  logic signed [blsd_pkg::ValueW-1:0] pool [8] = '{32'sh8000_0000, 32'sh7fff_ffff,
                                                   32'sh0000_0000, -32'sd1, 32'sd1,
                                                   32'sh5555_5555, 32'sh0f0f_0f0f,
                                                   -32'sd2};

  always #5 clk_i = ~clk_i;

  bounded_list_search_delete_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  blsd_list_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_cnt),
    .pending_o    (pending),
    .list_len_o   (list_len)
  );

  // Presents one request word at a falling edge and holds it until the
  // block takes it; returns at the falling edge after the accept.
  task automatic send_word(blsd_pkg::op_e op, logic signed [blsd_pkg::ValueW-1:0] v,
                           logic [blsd_pkg::PosW-1:0] p);
    req_if.valid    = 1'b1;
    req_if.op       = op;
    req_if.value    = v;
    req_if.position = p;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    // random gap between words, valid low for the whole burst
    if (!quiet && gaps_en && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  // Sender holds off until every outstanding result word is back.
  task automatic drain_wait();
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic blsd_pkg::op_e pick_op(phase_e ph);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_GROW: begin
        if (r < 85) return blsd_pkg::OP_APPEND;
        if (r < 95) return blsd_pkg::OP_FIND;
        return (r < 98) ? blsd_pkg::OP_REMOVE_VAL : blsd_pkg::OP_REMOVE_AT;
      end
      PH_SHRINK: begin
        if (r < 15) return blsd_pkg::OP_APPEND;
        if (r < 30) return blsd_pkg::OP_FIND;
        return (r < 65) ? blsd_pkg::OP_REMOVE_VAL : blsd_pkg::OP_REMOVE_AT;
      end
      default: begin
        if (r < 35) return blsd_pkg::OP_APPEND;
        if (r < 60) return blsd_pkg::OP_FIND;
        return (r < 80) ? blsd_pkg::OP_REMOVE_VAL : blsd_pkg::OP_REMOVE_AT;
      end
    endcase
  endfunction

  // Appends favor the pool half the time; lookups more often so they hit.
  function automatic logic signed [blsd_pkg::ValueW-1:0] pick_value(blsd_pkg::op_e op);
    int unsigned pool_pct;
    pool_pct = (op == blsd_pkg::OP_APPEND) ? 50 : 60;
    if ($urandom_range(0, 99) < pool_pct) return pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // Mostly in range, sometimes the ends of the list, sometimes past it.
  function automatic logic [blsd_pkg::PosW-1:0] pick_position(int len);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7 && len > 0) return blsd_pkg::PosW'($urandom_range(0, len - 1));
    if (r == 7) return (len > 0 && $urandom_range(0, 1)) ? blsd_pkg::PosW'(len - 1) : '0;
    if (len < blsd_pkg::DefDepth) begin
      return blsd_pkg::PosW'($urandom_range(len, blsd_pkg::DefDepth - 1));
    end
    return blsd_pkg::PosW'(blsd_pkg::DefDepth - 1);
  endfunction

  // result side: ready drops in random bursts, never in the quiet tail
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
    end
  end

  // hard stop in case the block hangs
  initial begin
    #(LimitTime);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    phase_e        ph;
    int unsigned   n;
    int unsigned   phase_items;
    blsd_pkg::op_e op;

    req_if.valid    = 1'b0;
    req_if.op       = blsd_pkg::OP_APPEND;
    req_if.value    = '0;
    req_if.position = '0;
    quiet           = 1'b0;
    gaps_en         = 1'b1;
    rst_ni          = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed ----
    // empty list: every lookup misses, every position is out of range
    send_word(blsd_pkg::OP_FIND,       32'sd5, 8'd0);
    send_word(blsd_pkg::OP_REMOVE_VAL, 32'sd5, 8'd0);
    send_word(blsd_pkg::OP_REMOVE_AT,  32'sd0, 8'd0);
    send_word(blsd_pkg::OP_REMOVE_AT,  32'sd0, 8'd255);
    // extremes and a duplicate of -1
    send_word(blsd_pkg::OP_APPEND, 32'sh8000_0000, 8'd0);
    send_word(blsd_pkg::OP_APPEND, 32'sh7fff_ffff, 8'd0);
    send_word(blsd_pkg::OP_APPEND, 32'sh0000_0000, 8'd0);
    send_word(blsd_pkg::OP_APPEND, -32'sd1,        8'd0);
    send_word(blsd_pkg::OP_APPEND, 32'sh5555_5555, 8'd0);
    send_word(blsd_pkg::OP_APPEND, 32'shAAAA_AAAA, 8'd0);
    send_word(blsd_pkg::OP_APPEND, -32'sd1,        8'd0);
    // lowest match wins for the duplicate
    send_word(blsd_pkg::OP_FIND, -32'sd1,        8'd0);
    send_word(blsd_pkg::OP_FIND, 32'sh8000_0000, 8'd0);
    send_word(blsd_pkg::OP_FIND, 32'sh7fff_ffff, 8'd0);
    send_word(blsd_pkg::OP_FIND, 32'sd12345,     8'd0);
    // position equal to length is out of range; then last and first entry
    send_word(blsd_pkg::OP_REMOVE_AT, 32'sd0, 8'd7);
    send_word(blsd_pkg::OP_REMOVE_AT, 32'sd0, 8'd6);
    send_word(blsd_pkg::OP_REMOVE_AT, 32'sd0, 8'd0);
    // remove by value: a middle hit, a miss, the one -1 left
    send_word(blsd_pkg::OP_REMOVE_VAL, 32'sd0,     8'd0);
    send_word(blsd_pkg::OP_REMOVE_VAL, 32'sd12345, 8'd0);
    send_word(blsd_pkg::OP_REMOVE_VAL, -32'sd1,    8'd0);
    drain_wait();

    // ---- random ----
    // mix first, then grow until full (appends past full report it), shrink,
    // and mix again to the end
    ph          = PH_MIX;
    phase_items = 0;
    for (n = 0; n < ItemCount; n++) begin
      if (n % 50 == 0) gaps_en = ($urandom_range(0, 9) < 7);
      quiet = (n >= ItemCount - QuietItems);
      case (ph)
        PH_MIX: begin
          if (n == 150) begin
            drain_wait();
            ph          = PH_GROW;
            phase_items = 0;
          end
        end
        PH_GROW: begin
          if (list_len >= blsd_pkg::DefDepth) phase_items++;
          if (phase_items > 16) begin
            ph          = PH_SHRINK;
            phase_items = 0;
          end
        end
        default: begin
          phase_items++;
          if (phase_items > 150) ph = PH_MIX;
        end
      endcase
      op = pick_op(ph);
      send_word(op, pick_value(op), pick_position(list_len));
    end
    req_if.valid = 1'b0;

    // let everything drain, then a tail for any stray word
    while (pending != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (fail_cnt == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/blsd_pkg.sv
src/blsd_req_if.sv
src/blsd_rsp_if.sv
src/bounded_list_search_delete_top.sv
dv/blsd_list_checker.sv
dv/tb_bounded_list_search_delete_top.sv
